// ===== rtl/pbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// pbrl_pkg
// Types, constants and the character decode shared by the pitch-bend
// run-length decoder modules.
// ----------------------------------------------------------------------------
package pbrl_pkg;

  // Sample store size and the run text length at which a run's count drops to zero
  localparam int STORE_SAMPLES  = 4096;
  localparam int RUN_TEXT_LIMIT = 8;

  // Field widths of the channels
  localparam int CHAR_W   = 8;
  localparam int SAMPLE_W = 12;
  localparam int SEXTET_W = 6;
  localparam int COUNT_W  = 13;

  // Internal widths
  localparam int TOTAL_W   = $clog2(STORE_SAMPLES + 1);
  localparam int RUN_NUM_W = 24;
  localparam int LEN_W     = 4;
  localparam int LEN_CMP_W = LEN_W + 1;

  localparam logic [LEN_W-1:0]     LEN_MAX   = '1;
  localparam logic [LEN_CMP_W-1:0] LEN_LIMIT = LEN_CMP_W'(RUN_TEXT_LIMIT);

  // Default depth of each queue
  localparam int FIFO_DEPTH = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;

  // Sextet offsets of the base64 alphabet
  localparam logic [CHAR_W-1:0] LC_OFFSET    = 8'd26;
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd52;
  localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
  localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [COUNT_W-1:0]         repeat_count;
    logic                       string_end;
    logic [COUNT_W-1:0]         total_samples;
  } out_item_t;

  // Store command from the parser to the store accounting
  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic [RUN_NUM_W-1:0] count;
    logic                 last;
  } cmd_t;

  // base64 character to sextet; anything outside the alphabet maps to 0
  function automatic logic [SEXTET_W-1:0] sextet_of(input logic [CHAR_W-1:0] c);
    logic [SEXTET_W-1:0] s;
    s = '0;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      s = SEXTET_W'(c - CHAR_UC_A);
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      s = SEXTET_W'(c - CHAR_LC_A + LC_OFFSET);
    end else if (c >= CHAR_0 && c <= CHAR_9) begin
      s = SEXTET_W'(c - CHAR_0 + DIGIT_OFFSET);
    end else if (c == CHAR_PLUS) begin
      s = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s = SEXTET_SLASH;
    end
    return s;
  endfunction

endpackage

// ===== rtl/pitch_bend_run_length_decoder.sv =====
// ----------------------------------------------------------------------------
// pitch_bend_run_length_decoder
// Decodes base64 pitch-bend text with '#count#' runs into stored samples.
// ----------------------------------------------------------------------------
// One character is taken per clock, back to back, with no gaps: full only
// rises when results are not being popped and both queues have filled. A
// character turns into a store command in the parser the cycle it is
// transferred and is written into the command queue at that edge; the
// accounting stage reads it from the queue once a result slot is free and
// writes the result into the result queue, from which it shows on out_item.
// The sustained rate of one character per clock is set by the parser's state
// update and by the total accumulator, which closes one compare and add per
// clock. Pairs of base64 characters give a 12-bit signed sample with a count
// of one; a run gives the last sample with its decimal count (zero when the
// run text reaches RUN_TEXT_LIMIT characters); every count is clipped to the
// space left in a store of STORE_SAMPLES samples. The last character of a
// text always yields a result marked string_end with the saturated total,
// an end-only one with zero sample and count when it closes nothing, and
// then all state returns to reset.
// ----------------------------------------------------------------------------
module pitch_bend_run_length_decoder #(
  parameter int FIFO_DEPTH = pbrl_pkg::FIFO_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // input queue side
  input  logic                push,
  output logic                full,
  input  pbrl_pkg::in_item_t  in_item,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output pbrl_pkg::out_item_t out_item
);
  import pbrl_pkg::*;

  // parser to command queue
  logic      in_xfer;
  logic      fe_cmd_valid;
  cmd_t      fe_cmd;

  // command queue to accounting
  logic      cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_head;

  // accounting to result queue
  logic      res_full, res_push;
  out_item_t res;

  // a character transfers whenever the command queue has room; the parser
  // issues at most one command per character
  assign in_xfer = push && !cmd_full;
  assign full    = cmd_full;

  pbrl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_xfer),
    .in_item   (in_item),
    .cmd_valid (fe_cmd_valid),
    .cmd       (fe_cmd)
  );

  // decouples parsing from store accounting
  pbrl_fifo #(
    .data_t (cmd_t),
    .DEPTH  (FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fe_cmd_valid),
    .push_data (fe_cmd),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_head),
    .empty     (cmd_empty)
  );

  pbrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue: results wait here while new characters keep flowing
  pbrl_fifo #(
    .data_t (out_item_t),
    .DEPTH  (FIFO_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_item),
    .empty     (empty)
  );

  // the parser never offers a command the queue cannot take
  a_no_cmd_drop: assert property (@(posedge clk) disable iff (!rst_n)
    fe_cmd_valid |-> !cmd_full)
    else $error("command issued into a full queue");

  // accounting only moves when a result slot is free
  a_no_res_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!res_full && !cmd_empty))
    else $error("result pushed into a full queue");

  // an end result never reports more than the store holds
  a_end_total: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.string_end) |-> (res.total_samples <= COUNT_W'(STORE_SAMPLES)))
    else $error("end total above store size");

endmodule

// ===== rtl/pbrl_fifo.sv =====
// ----------------------------------------------------------------------------
// pbrl_fifo
// Small register queue with a registered store and count-based full/empty.
// ----------------------------------------------------------------------------
module pbrl_fifo #(
  parameter type data_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  data_t push_data,
  output logic  full,
  input  logic  pop,
  output data_t pop_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

  data_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_DEPTH);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_DEPTH)
    else $error("fifo count above depth");

  // pointers move in step with the count
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("fifo count missed a push");

endmodule

// ===== rtl/pbrl_front.sv =====
// ----------------------------------------------------------------------------
// pbrl_front
// Character parser: pairs base64 characters into samples, collects run
// counts and issues one store command per sample, run or text end.
// ----------------------------------------------------------------------------
module pbrl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pbrl_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output pbrl_pkg::cmd_t    cmd
);
  import pbrl_pkg::*;

  logic                 pair_half_r, pair_half_nxt;
  logic [SEXTET_W-1:0]  first_sextet_r, first_sextet_nxt;
  logic                 in_run_r, in_run_nxt;
  logic [RUN_NUM_W-1:0] run_number_r, run_number_nxt;
  logic [LEN_W-1:0]     run_len_r, run_len_nxt;
  logic                 digits_stopped_r, digits_stopped_nxt;
  logic [SAMPLE_W-1:0]  prev_sample_r, prev_sample_nxt;

  logic                 is_hash, is_digit, emit;
  logic [SEXTET_W-1:0]  sextet;
  logic [RUN_NUM_W-1:0] digit_val, run_times_ten;
  logic [LEN_CMP_W-1:0] run_len_ext;

  assign is_hash       = (in_item.char_code == CHAR_HASH);
  assign is_digit      = (in_item.char_code >= CHAR_0) && (in_item.char_code <= CHAR_9);
  assign sextet        = sextet_of(in_item.char_code);
  assign digit_val     = RUN_NUM_W'(in_item.char_code - CHAR_0);
  assign run_times_ten = (run_number_r << 3) + (run_number_r << 1);
  assign run_len_ext   = LEN_CMP_W'(run_len_r);

  always_comb begin
    pair_half_nxt      = pair_half_r;
    first_sextet_nxt   = first_sextet_r;
    in_run_nxt         = in_run_r;
    run_number_nxt     = run_number_r;
    run_len_nxt        = run_len_r;
    digits_stopped_nxt = digits_stopped_r;
    prev_sample_nxt    = prev_sample_r;
    emit               = 1'b0;
    cmd                = '0;

    if (in_run_r) begin
      if (is_hash) begin
        // closing hash: repeat the last sample
        emit               = 1'b1;
        cmd.sample         = prev_sample_r;
        cmd.count          = (run_len_ext < LEN_LIMIT) ? run_number_r : '0;
        in_run_nxt         = 1'b0;
        run_number_nxt     = '0;
        run_len_nxt        = '0;
        digits_stopped_nxt = 1'b0;
      end else begin
        if (!digits_stopped_r) begin
          if (is_digit) begin
            if (run_len_ext + 1'b1 < LEN_LIMIT) begin
              run_number_nxt = run_times_ten + digit_val;
            end
          end else begin
            digits_stopped_nxt = 1'b1;
          end
        end
        if (run_len_r != LEN_MAX) begin
          run_len_nxt = run_len_r + 1'b1;
        end
      end
    end else if (pair_half_r) begin
      // second character of a pair, a hash here is plain data
      prev_sample_nxt = {first_sextet_r, sextet};
      pair_half_nxt   = 1'b0;
      emit            = 1'b1;
      cmd.sample      = {first_sextet_r, sextet};
      cmd.count       = RUN_NUM_W'(1);
    end else if (is_hash) begin
      in_run_nxt         = 1'b1;
      run_number_nxt     = '0;
      run_len_nxt        = '0;
      digits_stopped_nxt = 1'b0;
    end else begin
      first_sextet_nxt = sextet;
      pair_half_nxt    = 1'b1;
    end

    cmd.last = in_item.last_char;

    // text end puts the parser back to its idle state
    if (in_item.last_char) begin
      pair_half_nxt      = 1'b0;
      first_sextet_nxt   = '0;
      in_run_nxt         = 1'b0;
      run_number_nxt     = '0;
      run_len_nxt        = '0;
      digits_stopped_nxt = 1'b0;
      prev_sample_nxt    = '0;
    end
  end

  assign cmd_valid = in_valid && (emit || in_item.last_char);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_half_r      <= 1'b0;
      first_sextet_r   <= '0;
      in_run_r         <= 1'b0;
      run_number_r     <= '0;
      run_len_r        <= '0;
      digits_stopped_r <= 1'b0;
      prev_sample_r    <= '0;
    end else if (in_valid) begin
      pair_half_r      <= pair_half_nxt;
      first_sextet_r   <= first_sextet_nxt;
      in_run_r         <= in_run_nxt;
      run_number_r     <= run_number_nxt;
      run_len_r        <= run_len_nxt;
      digits_stopped_r <= digits_stopped_nxt;
      prev_sample_r    <= prev_sample_nxt;
    end
  end

  // a pending pair half and an open run never coexist
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pair_half_r && in_run_r))
    else $error("pair half pending inside a run");

  // the character after a text end starts from idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_item.last_char) |=>
      (!pair_half_r && !in_run_r && prev_sample_r == '0))
    else $error("parser state kept past text end");

endmodule

// ===== rtl/pbrl_back.sv =====
// ----------------------------------------------------------------------------
// pbrl_back
// Store accounting: clips each command's count to the space left, keeps the
// running total and builds the result item.
// ----------------------------------------------------------------------------
module pbrl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  pbrl_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output pbrl_pkg::out_item_t res
);
  import pbrl_pkg::*;

  localparam logic [TOTAL_W-1:0] STORE_LIM = TOTAL_W'(STORE_SAMPLES);

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] space, reps, total_sum;

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;

  always_comb begin
    space     = (total_r < STORE_LIM) ? STORE_LIM - total_r : '0;
    reps      = (cmd.count > RUN_NUM_W'(space)) ? space : TOTAL_W'(cmd.count);
    total_sum = total_r + reps;
    total_nxt = cmd.last ? '0 : total_sum;

    res.sample_value  = cmd.sample;
    res.repeat_count  = COUNT_W'(reps);
    res.string_end    = cmd.last;
    res.total_samples = COUNT_W'(total_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd_pop) begin
      total_r <= total_nxt;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= STORE_LIM)
    else $error("sample total above store size");

  a_reps_clip: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (RUN_NUM_W'(reps) <= cmd.count))
    else $error("stored more than requested");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.last) |=> (total_r == '0))
    else $error("total not cleared after text end");

endmodule
